// ===== hw/rtl/stt_pkg.sv =====
`default_nettype none

package stt_pkg;

  // Default table depth
  localparam int CAPACITY_DEF = 64;

  // Field widths
  localparam int ID_W    = 31;
  localparam int TICKS_W = 29;
  localparam int MS_W    = 32;
  localparam int KIND_W  = 2;

  // Input action codes
  localparam logic ACT_SLEEP = 1'b0;
  localparam logic ACT_TICK  = 1'b1;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_ACCEPTED = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FULL     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_WOKEN    = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NONE     = 2'd3;

  // One tick is 10 ms; ms / 10 is (ms * ceil(2^35 / 10)) >> 35, exact over 32 bits
  localparam int          MS_PER_TICK = 10;
  localparam int          MS_SHIFT    = 35;
  localparam logic [31:0] MS_RECIP    =
    32'(((64'd1 << MS_SHIFT) + 64'(MS_PER_TICK) - 64'd1) / 64'(MS_PER_TICK));

  // Cell operations
  localparam logic [1:0] OP_HOLD = 2'd0;
  localparam logic [1:0] OP_SHL  = 2'd1;  // take the right-hand neighbour
  localparam logic [1:0] OP_SHR  = 2'd2;  // take the left-hand neighbour
  localparam logic [1:0] OP_LOAD = 2'd3;  // take the broadcast entry if addressed

  typedef struct packed {
    logic              action;
    logic [ID_W-1:0]   task_id;
    logic [MS_W-1:0]   sleep_ms;
  } in_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   woken_id;
    logic              last;
  } out_t;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [TICKS_W-1:0] ticks;
  } entry_t;

  typedef struct packed {
    logic [1:0] op;
    entry_t     data;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/stt_cell.sv =====
`default_nettype none

module stt_cell #(
  parameter int IDX_W = $clog2(stt_pkg::CAPACITY_DEF),
  parameter int INDEX = 0
) (
  input  logic               clk,
  input  stt_pkg::cell_ctrl_t ctrl,
  input  logic [IDX_W-1:0]   idx,
  input  stt_pkg::entry_t    left_in,
  input  stt_pkg::entry_t    right_in,
  output stt_pkg::entry_t    entry
);

  // Shift, load or hold the stored entry
  always_ff @(posedge clk) begin
    case (ctrl.op)
      stt_pkg::OP_SHL: entry <= right_in;
      stt_pkg::OP_SHR: entry <= left_in;
      stt_pkg::OP_LOAD: begin
        if (idx == IDX_W'(INDEX)) begin
          entry <= ctrl.data;
        end
      end
      default: entry <= entry;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/stt_chain.sv =====
`default_nettype none

module stt_chain #(
  parameter int CAPACITY = stt_pkg::CAPACITY_DEF,
  parameter int IDX_W    = $clog2(stt_pkg::CAPACITY_DEF)
) (
  input  logic                clk,
  input  stt_pkg::cell_ctrl_t ctrl,
  input  logic [IDX_W-1:0]    idx,
  output stt_pkg::entry_t     head
);

  stt_pkg::entry_t entries [CAPACITY];

  // Build the row; cell 0 takes the broadcast entry on a right shift
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    stt_pkg::entry_t left_in;
    stt_pkg::entry_t right_in;

    if (k == 0) begin : g_first
      assign left_in = ctrl.data;
    end else begin : g_inner_l
      assign left_in = entries[k-1];
    end

    if (k == CAPACITY - 1) begin : g_end
      assign right_in = entries[k];
    end else begin : g_inner_r
      assign right_in = entries[k+1];
    end

    stt_cell #(
      .IDX_W (IDX_W),
      .INDEX (k)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .idx      (idx),
      .left_in  (left_in),
      .right_in (right_in),
      .entry    (entries[k])
    );
  end

  assign head = entries[0];

endmodule

`default_nettype wire

// ===== hw/rtl/sleep_timer_table_core.sv =====
`default_nettype none

// Channel   Handshake          Payload             Notes
// command   start / busy       item   (in_t)       accepted when start && !busy
// result    strobe             result (out_t)      valid for one cycle, no back-pressure
//
// A sleep transaction registers ms / 10 from the multiplier, then appends the entry in
// S_INS; a refused one is answered straight from idle. A tick examines one entry per
// cycle at the head of the cell rows, a closing step ends the scan, and survivors are
// copied back one per cycle.
// Reset clears the entry count and the sequencer; the cell rows are not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.

module sleep_timer_table_core #(
  parameter int CAPACITY = stt_pkg::CAPACITY_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  stt_pkg::in_t  item,
  output logic          strobe,
  output stt_pkg::out_t result
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW    = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_CW = CW'(CAPACITY);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_INS   = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_DRAIN = 2'd3;

  logic [1:0]    state;
  logic [CW-1:0] count;
  logic [CW-1:0] remain;
  logic [CW-1:0] pcount;
  logic [CW-1:0] dcount;
  logic          from_back;
  logic          pend_valid;
  logic [stt_pkg::ID_W-1:0]    pend_id;
  logic [stt_pkg::ID_W-1:0]    ins_id;
  logic [stt_pkg::TICKS_W-1:0] ins_ticks;

  logic [63:0]         prod;
  stt_pkg::entry_t     fw_head;
  stt_pkg::entry_t     bk_head;
  stt_pkg::entry_t     pq_head;
  stt_pkg::entry_t     cand;
  stt_pkg::entry_t     cand_dec;
  stt_pkg::cell_ctrl_t fw_ctrl;
  stt_pkg::cell_ctrl_t bk_ctrl;
  stt_pkg::cell_ctrl_t pq_ctrl;
  logic [IDX_W-1:0]    fw_idx;
  logic [IDX_W-1:0]    pq_idx;

  assign busy = (state != S_IDLE);

  // Scale milliseconds to ticks by the reciprocal of ten
  assign prod = 64'(item.sleep_ms) * 64'(stt_pkg::MS_RECIP);

  // Pick the entry under examination: the front row, or the tail after a wake
  assign cand           = from_back ? bk_head : fw_head;
  assign cand_dec.id    = cand.id;
  assign cand_dec.ticks = cand.ticks - stt_pkg::TICKS_W'(1);

  // Drive the three cell rows
  always_comb begin
    fw_ctrl = '{op: stt_pkg::OP_HOLD, data: pq_head};
    bk_ctrl = '{op: stt_pkg::OP_HOLD, data: pq_head};
    pq_ctrl = '{op: stt_pkg::OP_HOLD, data: cand_dec};
    fw_idx  = dcount[IDX_W-1:0];
    pq_idx  = pcount[IDX_W-1:0];
    case (state)
      S_INS: begin
        fw_ctrl = '{op: stt_pkg::OP_LOAD, data: '{id: ins_id, ticks: ins_ticks}};
        bk_ctrl = '{op: stt_pkg::OP_SHR,  data: '{id: ins_id, ticks: ins_ticks}};
        fw_idx  = count[IDX_W-1:0];
      end
      S_SCAN: begin
        if (remain != '0) begin
          if (from_back) begin
            bk_ctrl.op = stt_pkg::OP_SHL;
          end else begin
            fw_ctrl.op = stt_pkg::OP_SHL;
          end
          if (cand.ticks != '0) begin
            pq_ctrl.op = stt_pkg::OP_LOAD;
          end
        end
      end
      S_DRAIN: begin
        pq_ctrl.op = stt_pkg::OP_SHL;
        fw_ctrl.op = stt_pkg::OP_LOAD;
        bk_ctrl.op = stt_pkg::OP_SHR;
      end
      default: begin
        fw_ctrl.op = stt_pkg::OP_HOLD;
      end
    endcase
  end

  // Front row: entries in table order, head is the lowest index
  stt_chain #(.CAPACITY(CAPACITY), .IDX_W(IDX_W)) u_front (
    .clk (clk), .ctrl (fw_ctrl), .idx (fw_idx), .head (fw_head)
  );

  // Back row: entries in reverse order, head is the last entry
  stt_chain #(.CAPACITY(CAPACITY), .IDX_W(IDX_W)) u_back (
    .clk (clk), .ctrl (bk_ctrl), .idx (fw_idx), .head (bk_head)
  );

  // Survivor row: decremented entries collected during a tick
  stt_chain #(.CAPACITY(CAPACITY), .IDX_W(IDX_W)) u_keep (
    .clk (clk), .ctrl (pq_ctrl), .idx (pq_idx), .head (pq_head)
  );

  // Sequence transactions and register results
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      strobe     <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            if (item.action == stt_pkg::ACT_TICK) begin
              remain     <= count;
              pcount     <= '0;
              from_back  <= 1'b0;
              pend_valid <= 1'b0;
              state      <= S_SCAN;
            end else if (count == CAP_CW) begin
              strobe <= 1'b1;
              result <= '{kind: stt_pkg::KIND_FULL, woken_id: '0, last: 1'b1};
            end else begin
              ins_id    <= item.task_id;
              ins_ticks <= prod[stt_pkg::MS_SHIFT +: stt_pkg::TICKS_W];
              state     <= S_INS;
            end
          end
        end
        S_INS: begin
          count  <= count + CW'(1);
          strobe <= 1'b1;
          result <= '{kind: stt_pkg::KIND_ACCEPTED, woken_id: '0, last: 1'b1};
          state  <= S_IDLE;
        end
        S_SCAN: begin
          if (remain == '0) begin
            // Close the tick with the held wake, or report none
            strobe <= 1'b1;
            if (pend_valid) begin
              result <= '{kind: stt_pkg::KIND_WOKEN, woken_id: pend_id, last: 1'b1};
            end else begin
              result <= '{kind: stt_pkg::KIND_NONE, woken_id: '0, last: 1'b1};
            end
            pend_valid <= 1'b0;
            count      <= pcount;
            dcount     <= '0;
            state      <= (pcount == '0) ? S_IDLE : S_DRAIN;
          end else begin
            remain <= remain - CW'(1);
            if (cand.ticks == '0) begin
              // Release the previous wake and hold this one back
              if (pend_valid) begin
                strobe <= 1'b1;
                result <= '{kind: stt_pkg::KIND_WOKEN, woken_id: pend_id, last: 1'b0};
              end
              pend_id    <= cand.id;
              pend_valid <= 1'b1;
              from_back  <= 1'b1;
            end else begin
              pcount    <= pcount + CW'(1);
              from_back <= 1'b0;
            end
          end
        end
        S_DRAIN: begin
          // Copy survivors back into both rows
          dcount <= dcount + CW'(1);
          if ((dcount + CW'(1)) == count) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_insert_last: assert property (@(posedge clk) disable iff (rst)
    strobe && (result.kind == stt_pkg::KIND_ACCEPTED || result.kind == stt_pkg::KIND_FULL)
    |-> result.last)
    else $error("insert result without last");

  a_id_zero: assert property (@(posedge clk) disable iff (rst)
    strobe && (result.kind != stt_pkg::KIND_WOKEN) |-> (result.woken_id == '0))
    else $error("non-wake result carries an id");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CAP_CW)
    else $error("entry count beyond capacity");

  a_scan_books: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (({1'b0, pcount} + {1'b0, remain}) <= {1'b0, count}))
    else $error("survivors and remaining exceed stored entries");

  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (item.action == stt_pkg::ACT_TICK) |=> busy)
    else $error("tick accepted without going busy");
`endif

endmodule

`default_nettype wire
